/* sv/sfir_pkg.sv */
// sfir_pkg: shared types, constants and coefficient tables of the selectable fir/iir filter
// no dependencies; imported by the interfaces, the mac unit, the top level and the checker

package sfir_pkg;

   localparam int DEF_MAX_TAPS    = 22;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int COEF_W     = 32;   // q3.28 coefficients
   localparam int COEF_FRAC  = 28;
   localparam int FB_W       = 40;   // q17.22 feedback values
   localparam int FB_FRAC    = 22;
   localparam int FB_TAPS    = 3;
   localparam int FB_CNT_W   = 3;    // counts two half products per feedback tap
   localparam int COEF_IDX_W = 7;
   localparam int MODE_W     = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIR4  = 2'd0,
      MODE_FIR7  = 2'd1,
      MODE_FIR22 = 2'd2,
      MODE_IIR   = 2'd3
   } sfir_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_FB,
      ST_DRAIN,
      ST_SAT,
      ST_OUT
   } sfir_state_type;

   typedef struct packed {
      logic clear;   // load the rounding constant into the accumulator
      logic issue;   // a new product enters the multiplier register
      logic shift;   // product is scaled up by the feedback fraction bits
   } sfir_mac_ctl_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type TAPS4 [4] = '{
      32'sd42787201, 32'sd102764101, 32'sd102764101, 32'sd42787201
   };

   localparam coef_type TAPS7 [7] = '{
      32'sd7451016, 32'sd48652197, 32'sd55708115, 32'sd66188808,
      32'sd55708115, 32'sd48652197, 32'sd7451016
   };

   localparam coef_type TAPS22 [22] = '{
      -32'sd1278413, 32'sd1997236, 32'sd3498475, 32'sd5960953,
      32'sd9141736, 32'sd12811628, 32'sd16678690, 32'sd20391998,
      32'sd23593795, 32'sd25944353, 32'sd27190365, 32'sd27190365,
      32'sd25944353, 32'sd23593795, 32'sd20391998, 32'sd16678690,
      32'sd12811628, 32'sd9141736, 32'sd5960953, 32'sd3498475,
      32'sd1997236, -32'sd1278413
   };

   localparam coef_type IIR_B [4] = '{
      32'sd1069209, -32'sd956786, -32'sd956786, 32'sd1069209
   };

   // negated feedback coefficients
   localparam coef_type IIR_NA [FB_TAPS] = '{
      32'sd753833057, -32'sd707182318, 32'sd221559871
   };

   // feed-forward coefficient of tap idx; zero past the end of the filter
   function automatic coef_type sfir_coef(input sfir_mode_type mode,
                                          input logic [COEF_IDX_W-1:0] idx);
      coef_type c;
      c = '0;
      unique case (mode)
         MODE_FIR4: begin
            if (idx < COEF_IDX_W'(4)) c = TAPS4[idx[1:0]];
         end
         MODE_FIR7: begin
            if (idx < COEF_IDX_W'(7)) c = TAPS7[idx[2:0]];
         end
         MODE_FIR22: begin
            if (idx < COEF_IDX_W'(22)) c = TAPS22[idx[4:0]];
         end
         MODE_IIR: begin
            if (idx < COEF_IDX_W'(4)) c = IIR_B[idx[1:0]];
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

/* sv/sfir_if.sv */
// sfir_if: valid/ready channel interfaces for sample requests, filtered responses and
// the mode register write port; depends on sfir_pkg for default widths

interface sfir_req_if import sfir_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface sfir_rsp_if import sfir_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface sfir_csr_if import sfir_pkg::*;;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] filter_mode;

   modport source (output valid, output filter_mode, input ready);
   modport sink   (input valid, input filter_mode, output ready);
endinterface

/* sv/sfir_mac.sv */
// sfir_mac: shared signed multiply-accumulate unit with a registered product stage
// depends on sfir_pkg (control struct, coefficient width, fraction widths)

module sfir_mac import sfir_pkg::*; #(
   parameter int A_W   = 23,
   parameter int ACC_W = 83
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sfir_mac_ctl_type        ctl,
   input  logic signed [A_W-1:0]   a_op,
   input  coef_type                c_op,
   output logic signed [ACC_W-1:0] acc
);

   localparam int PROD_W = A_W + COEF_W;
   localparam logic signed [ACC_W-1:0] ROUND_INIT = ACC_W'(1) <<< (COEF_FRAC - 1);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pvalid_ff, pvalid_in;
   logic                     shift_ff, shift_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  addend;

   always_comb begin
      prod_in   = a_op * c_op;
      pvalid_in = ctl.issue;
      shift_in  = ctl.shift;
      if (shift_ff) begin
         addend = ACC_W'(prod_ff) <<< FB_FRAC;
      end else begin
         addend = ACC_W'(prod_ff);
      end
      // rounding constant preloaded so the final step is a plain arithmetic shift
      if (ctl.clear) begin
         acc_in = ROUND_INIT;
      end else if (pvalid_ff) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         shift_ff  <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
         shift_ff  <= shift_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* sv/selectable_fir_iir_filter_unit.sv */
// selectable_fir_iir_filter_unit: 4/7/22-tap fir or third-order iir on one shared mac unit
// depends on sfir_pkg, sfir_if (channel interfaces) and sfir_mac
//
//   channel   | dir | payload                          | handshake
//   ----------+-----+----------------------------------+-------------------
//   req_port  | in  | sample_in (SAMPLE_BITS, signed)  | valid/ready
//   rsp_port  | out | sample_out (signed), clipped     | valid/ready
//   csr_port  | in  | filter_mode (2 bits)             | valid/ready, always ready
//
// a word is taken in ST_IDLE and then passes through ST_MAC, ST_FB (iir mode only),
// ST_DRAIN, ST_SAT and ST_OUT; ready stays low until the block is back in ST_IDLE, so no
// new word is taken before the last one is through. the single mac unit walks every
// tap of the rotating delay line, then, in iir mode, two half products per feedback tap.
// a response waits in its output register while the next word is accepted; the block
// only stalls before loading the output register if the previous word was not taken.
// reset and every mode write clear both histories at once.

module selectable_fir_iir_filter_unit import sfir_pkg::*; #(
   parameter int MAX_TAPS    = DEF_MAX_TAPS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input logic         clock,
   input logic         reset,
   sfir_req_if.sink    req_port,
   sfir_rsp_if.source  rsp_port,
   sfir_csr_if.sink    csr_port
);

   localparam int A_W   = (SAMPLE_BITS > FB_FRAC) ? SAMPLE_BITS : FB_FRAC + 1;
   localparam int ACC_W = A_W + COEF_W + FB_FRAC + $clog2(MAX_TAPS + 2 * FB_TAPS) + 1;
   localparam int Q_W   = ACC_W - COEF_FRAC;
   localparam int TAP_W = $clog2(MAX_TAPS);

   localparam logic signed [Q_W-1:0]  F_HI   = Q_W'((64'sd1 <<< (FB_W - 1)) - 64'sd1);
   localparam logic signed [Q_W-1:0]  F_LO   = -F_HI - Q_W'(1);
   localparam logic signed [Q_W-1:0]  Y_HI   = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [Q_W-1:0]  Y_LO   = -Y_HI - Q_W'(1);
   localparam logic signed [FB_W:0]   FB_RND = (FB_W + 1)'(1) <<< (FB_FRAC - 1);

   sfir_state_type state_ff, state_in;
   sfir_mode_type  mode_ff, mode_in;
   logic [TAP_W-1:0]    tap_cnt_ff, tap_cnt_in;
   logic [FB_CNT_W-1:0] fb_cnt_ff, fb_cnt_in;

   logic signed [SAMPLE_BITS-1:0] hist_ff  [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_in  [MAX_TAPS];
   logic signed [FB_W-1:0]        ohist_ff [FB_TAPS];
   logic signed [FB_W-1:0]        ohist_in [FB_TAPS];

   logic signed [Q_W-1:0]         q_ff, q_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_out_ff, sample_out_in;
   logic                          clipped_ff, clipped_in;

   sfir_mac_ctl_type        mac_ctl;
   logic signed [A_W-1:0]   a_op;
   coef_type                c_op;
   logic signed [ACC_W-1:0] acc;

   logic req_fire, csr_fire, out_load, tap_last, fb_last;
   logic signed [Q_W-1:0]  q_full;
   logic signed [FB_W-1:0] f_sat;
   logic signed [FB_W:0]   f_rnd;

   sfir_mac #(
      .A_W   (A_W),
      .ACC_W (ACC_W)
   ) u_sfir_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a_op  (a_op),
      .c_op  (c_op),
      .acc   (acc)
   );

   assign req_fire = req_port.valid && req_port.ready;
   assign csr_fire = csr_port.valid && csr_port.ready;
   assign tap_last = (tap_cnt_ff == TAP_W'(MAX_TAPS - 1));
   assign fb_last  = (fb_cnt_ff == FB_CNT_W'(2 * FB_TAPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (tap_last) state_in = (mode_ff == MODE_IIR) ? ST_FB : ST_DRAIN;
         end
         ST_FB: begin
            if (fb_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_SAT;
         ST_SAT:   state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_port.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_port.ready = 1'b0;
      mac_ctl        = '0;
      a_op           = A_W'(hist_ff[0]);
      c_op           = '0;
      out_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // ready is high here, so a valid word is taken this cycle
            req_port.ready = 1'b1;
            mac_ctl.clear  = req_port.valid;
         end
         ST_MAC: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.shift = (mode_ff == MODE_IIR);
            c_op          = sfir_coef(mode_ff, COEF_IDX_W'(tap_cnt_ff));
         end
         ST_FB: begin
            // even step: integer part of the past output, odd step: its fraction
            mac_ctl.issue = 1'b1;
            mac_ctl.shift = !fb_cnt_ff[0];
            c_op          = IIR_NA[fb_cnt_ff[2:1]];
            if (fb_cnt_ff[0]) begin
               a_op = A_W'({1'b0, ohist_ff[0][FB_FRAC-1:0]});
            end else begin
               a_op = A_W'($signed(ohist_ff[0][FB_W-1:FB_FRAC]));
            end
         end
         ST_OUT: begin
            out_load = !rsp_valid_ff || rsp_port.ready;
         end
         ST_DRAIN, ST_SAT: begin
            mac_ctl = '0;
         end
         default: begin
            mac_ctl = '0;
         end
      endcase
   end

   // rounding of the accumulator and feedback saturation
   always_comb begin
      q_full = acc[ACC_W-1:COEF_FRAC];
      if (q_full > F_HI) begin
         f_sat = FB_W'(F_HI);
      end else if (q_full < F_LO) begin
         f_sat = FB_W'(F_LO);
      end else begin
         f_sat = FB_W'(q_full);
      end
      f_rnd = (FB_W + 1)'(f_sat) + FB_RND;
   end

   // datapath next values
   always_comb begin
      mode_in       = mode_ff;
      hist_in       = hist_ff;
      ohist_in      = ohist_ff;
      tap_cnt_in    = '0;
      fb_cnt_in     = '0;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      sample_out_in = sample_out_ff;
      clipped_in    = clipped_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int j = MAX_TAPS - 1; j > 0; j--) hist_in[j] = hist_ff[j-1];
               hist_in[0] = req_port.sample_in;
            end
         end
         ST_MAC: begin
            // rotate so the next tap sits at the head; a full pass restores the order
            for (int j = 0; j < MAX_TAPS - 1; j++) hist_in[j] = hist_ff[j+1];
            hist_in[MAX_TAPS-1] = hist_ff[0];
            tap_cnt_in = TAP_W'(tap_cnt_ff + 1'b1);
         end
         ST_FB: begin
            if (fb_cnt_ff[0]) begin
               for (int j = 0; j < FB_TAPS - 1; j++) ohist_in[j] = ohist_ff[j+1];
               ohist_in[FB_TAPS-1] = ohist_ff[0];
            end
            fb_cnt_in = FB_CNT_W'(fb_cnt_ff + 1'b1);
         end
         ST_SAT: begin
            if (mode_ff == MODE_IIR) begin
               for (int j = FB_TAPS - 1; j > 0; j--) ohist_in[j] = ohist_ff[j-1];
               ohist_in[0] = f_sat;
               q_in = Q_W'($signed(f_rnd[FB_W:FB_FRAC]));
            end else begin
               q_in = q_full;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (q_ff > Y_HI) begin
                  sample_out_in = SAMPLE_BITS'(Y_HI);
                  clipped_in    = 1'b1;
               end else if (q_ff < Y_LO) begin
                  sample_out_in = SAMPLE_BITS'(Y_LO);
                  clipped_in    = 1'b1;
               end else begin
                  sample_out_in = SAMPLE_BITS'(q_ff);
                  clipped_in    = 1'b0;
               end
            end
         end
         default: begin
            q_in = q_ff;
         end
      endcase

      // any mode write restarts both histories
      if (csr_fire) begin
         mode_in = sfir_mode_type'(csr_port.filter_mode);
         for (int j = 0; j < MAX_TAPS; j++) hist_in[j] = '0;
         for (int j = 0; j < FB_TAPS; j++) ohist_in[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FIR4;
         tap_cnt_ff   <= '0;
         fb_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_TAPS; j++) hist_ff[j] <= '0;
         for (int j = 0; j < FB_TAPS; j++) ohist_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         tap_cnt_ff   <= tap_cnt_in;
         fb_cnt_ff    <= fb_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
         ohist_ff     <= ohist_in;
      end
      q_ff          <= q_in;
      sample_out_ff <= sample_out_in;
      clipped_ff    <= clipped_in;
   end

   assign csr_port.ready      = 1'b1;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.sample_out = sample_out_ff;
   assign rsp_port.clipped    = clipped_ff;

endmodule

/* sv/sfir_checker.sv */
// sfir_checker: port-level checks of the selectable fir/iir filter, bound to the top level
// depends on sfir_pkg and selectable_fir_iir_filter_unit

module sfir_checker import sfir_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_clipped
);

   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // one word at a time: busy right after a word is taken
   property p_busy_after_accept;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready) |=> !req_ready;
   endproperty
   a_busy_after_accept: assert property (p_busy_after_accept)
      else $error("request channel ready right after accepting a word");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("stalled response word changed or dropped");

   // a clipped word sits at one of the range limits
   property p_clip_at_limit;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_clipped) |-> (rsp_sample_out == S_MAX || rsp_sample_out == S_MIN);
   endproperty
   a_clip_at_limit: assert property (p_clip_at_limit)
      else $error("clipped flag set on a word inside the range");

   property p_reset_idle;
      @(posedge clock) reset |=> (!rsp_valid && req_ready);
   endproperty
   a_reset_idle: assert property (p_reset_idle)
      else $error("block not idle after reset");

endmodule

bind selectable_fir_iir_filter_unit sfir_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_sfir_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_sample_out (rsp_port.sample_out),
   .rsp_clipped    (rsp_port.clipped)
);

/* test/tb_selectable_fir_iir_filter_unit.sv */
// tb_selectable_fir_iir_filter_unit: self-checking bench for the selectable fir/iir filter unit
// drives random bursts of samples across all four modes, predicts each filtered word itself
// depends on sfir_pkg, sfir_if and the rtl of selectable_fir_iir_filter_unit
`timescale 1ns / 100ps

module tb_selectable_fir_iir_filter_unit;
   import sfir_pkg::*;

   typedef logic signed [15:0] sample_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               clipped;
   } filtered_word_type;

   localparam int LINE_DEPTH = 22;
   localparam longint HALF_Q28 = 64'sd134217728;
   localparam longint HALF_Q22 = 64'sd2097152;
   localparam longint FB_MAX = 64'sd549755813887;
   localparam longint FB_MIN = -64'sd549755813888;

   localparam longint FIR4_COEF [4] = '{42787201, 102764101, 102764101, 42787201};
   localparam longint FIR7_COEF [7] = '{
      7451016, 48652197, 55708115, 66188808, 55708115, 48652197, 7451016
   };
   localparam longint FIR22_COEF [22] = '{
      -1278413, 1997236, 3498475, 5960953, 9141736, 12811628,
      16678690, 20391998, 23593795, 25944353, 27190365, 27190365,
      25944353, 23593795, 20391998, 16678690, 12811628, 9141736,
      5960953, 3498475, 1997236, -1278413
   };
   localparam longint LOWPASS_B [4] = '{1069209, -956786, -956786, 1069209};
   // feedback coefficients already negated
   localparam longint LOWPASS_NEG_A [3] = '{753833057, -707182318, 221559871};

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfir_req_if req_bus ();
   sfir_rsp_if rsp_bus ();
   sfir_csr_if csr_bus ();

   selectable_fir_iir_filter_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   sfir_mode_type active_mode = MODE_FIR4;
   sample_type    sample_line [LINE_DEPTH];
   longint        lowpass_out [3];

   sample_type        samples_to_send [$];
   sfir_mode_type     mode_writes [$];
   filtered_word_type expected_filtered [$];

   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned ready_pct;
   int unsigned pattern_left;
   int unsigned hold_left;
   logic        hold_armed;
   logic        hold_request = 1'b0;
   logic        feed_steady = 1'b0;
   int unsigned error_count = 0;

   function automatic void clear_filter_state();
      for (int k = 0; k < LINE_DEPTH; k++) sample_line[k] = '0;
      for (int k = 0; k < 3; k++) lowpass_out[k] = 0;
   endfunction

   function automatic filtered_word_type filter_sample(input sample_type x);
      filtered_word_type word;
      longint acc;
      longint lo;
      longint fh;
      longint fl;
      longint f;
      longint res;
      word.clipped = 1'b0;
      acc = 0;
      for (int k = LINE_DEPTH - 1; k > 0; k--) sample_line[k] = sample_line[k-1];
      sample_line[0] = x;
      case (active_mode)
         MODE_FIR4: begin
            for (int k = 0; k < 4; k++) acc += longint'(sample_line[k]) * FIR4_COEF[k];
            res = (acc + HALF_Q28) >>> 28;
         end
         MODE_FIR7: begin
            for (int k = 0; k < 7; k++) acc += longint'(sample_line[k]) * FIR7_COEF[k];
            res = (acc + HALF_Q28) >>> 28;
         end
         MODE_FIR22: begin
            for (int k = 0; k < 22; k++) acc += longint'(sample_line[k]) * FIR22_COEF[k];
            res = (acc + HALF_Q28) >>> 28;
         end
         default: begin
            // feedback split into integer and fraction parts so nothing overflows 64 bits
            lo = 0;
            for (int k = 0; k < 4; k++) acc += longint'(sample_line[k]) * LOWPASS_B[k];
            for (int k = 0; k < 3; k++) begin
               fh = lowpass_out[k] >>> 22;
               fl = lowpass_out[k] - (fh <<< 22);
               acc += fh * LOWPASS_NEG_A[k];
               lo += fl * LOWPASS_NEG_A[k];
            end
            lo += HALF_Q28;
            f = (acc + (lo >>> 22)) >>> 6;
            if (f > FB_MAX) f = FB_MAX;
            else if (f < FB_MIN) f = FB_MIN;
            lowpass_out[2] = lowpass_out[1];
            lowpass_out[1] = lowpass_out[0];
            lowpass_out[0] = f;
            res = (f + HALF_Q22) >>> 22;
         end
      endcase
      if (res > 32767) begin
         res = 32767;
         word.clipped = 1'b1;
      end else if (res < -32768) begin
         res = -32768;
         word.clipped = 1'b1;
      end
      word.sample_out = res[15:0];
      return word;
   endfunction

   // mode register writer
   always @(posedge clock) begin
      if (reset) begin
         csr_bus.valid       <= 1'b0;
         csr_bus.filter_mode <= MODE_FIR4;
         active_mode = MODE_FIR4;
         clear_filter_state();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            active_mode = sfir_mode_type'(csr_bus.filter_mode);
            clear_filter_state();
         end
         if (!csr_bus.valid || csr_bus.ready) begin
            if (mode_writes.size() != 0) begin
               csr_bus.valid       <= 1'b1;
               csr_bus.filter_mode <= mode_writes.pop_front();
            end else begin
               csr_bus.valid <= 1'b0;
            end
         end
      end
   end

   // sample driver, bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.sample_in <= '0;
         burst_left        <= 0;
         gap_left          <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_filtered.push_back(filter_sample(req_bus.sample_in));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0 && !feed_steady) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (samples_to_send.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else begin
               req_bus.valid     <= 1'b1;
               req_bus.sample_in <= samples_to_send.pop_front();
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(0, 23);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && hold_armed) begin
         hold_left  <= 400;
         hold_armed <= 1'b0;
      end
   end

   // result checker with its own stall pattern
   always @(posedge clock) begin
      filtered_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_pct     <= 100;
         pattern_left  <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_filtered.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected word: sample_out=%0d clipped=%0b",
                           rsp_bus.sample_out, rsp_bus.clipped);
            end else begin
               want = expected_filtered.pop_front();
               if (rsp_bus.sample_out !== want.sample_out || rsp_bus.clipped !== want.clipped)
               begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                              want.sample_out, rsp_bus.sample_out, want.clipped,
                              rsp_bus.clipped);
               end
            end
         end
         if (pattern_left == 0) begin
            pattern_left <= $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0: ready_pct <= 100;
               1: ready_pct <= 80;
               2: ready_pct <= 45;
               default: ready_pct <= 15;
            endcase
         end else begin
            pattern_left <= pattern_left - 1;
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(1, 100) <= ready_pct);
      end
   end

   function automatic sample_type pick_extreme();
      case ($urandom_range(0, 4))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return 16'sh0001;
      endcase
   endfunction

   task automatic wait_until_drained();
      while (samples_to_send.size() != 0 || req_bus.valid || expected_filtered.size() != 0 ||
             mode_writes.size() != 0 || csr_bus.valid)
         @(negedge clock);
   endtask

   task automatic write_filter_mode(input sfir_mode_type mode);
      wait_until_drained();
      mode_writes.push_back(mode);
      while (mode_writes.size() != 0 || csr_bus.valid) @(negedge clock);
   endtask

   task automatic queue_random_samples(input int count);
      int queued;
      int run;
      sample_type level;
      queued = 0;
      while (queued < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               samples_to_send.push_back(sample_type'($urandom));
               queued++;
            end
            4, 5: begin
               // steady level, drives the low-pass and the long fir toward clipping
               run = $urandom_range(4, 30);
               level = ($urandom_range(0, 1) == 0) ? pick_extreme() : sample_type'($urandom);
               for (int k = 0; k < run && queued < count; k++) begin
                  samples_to_send.push_back(level);
                  queued++;
               end
            end
            6, 7: begin
               run = $urandom_range(4, 24);
               for (int k = 0; k < run && queued < count; k++) begin
                  samples_to_send.push_back(k[0] ? 16'sh8000 : 16'sh7fff);
                  queued++;
               end
            end
            default: begin
               run = $urandom_range(2, 12);
               for (int k = 0; k < run && queued < count; k++) begin
                  samples_to_send.push_back(sample_type'($urandom_range(0, 511)) - 16'sd256);
                  queued++;
               end
            end
         endcase
      end
   endtask

   initial begin
      sfir_mode_type phase_mode [8];
      int            phase_items [8];
      phase_mode  = '{MODE_FIR7, MODE_FIR22, MODE_IIR, MODE_IIR,
                      MODE_FIR4, MODE_FIR22, MODE_FIR7, MODE_IIR};
      phase_items = '{80, 80, 80, 90, 80, 80, 80, 100};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes and clipping in the short fir
      write_filter_mode(MODE_FIR4);
      repeat (4) samples_to_send.push_back(16'sh7fff);
      repeat (4) samples_to_send.push_back(16'sh8000);
      samples_to_send.push_back(16'sh0001);
      samples_to_send.push_back(16'shffff);
      samples_to_send.push_back(16'sh0000);
      // step response of the low-pass, both signs
      write_filter_mode(MODE_IIR);
      repeat (6) samples_to_send.push_back(16'sh7fff);
      repeat (6) samples_to_send.push_back(16'sh8000);

      for (int p = 0; p < 8; p++) begin
         // rewriting the same mode (phases 2 and 3) must still clear the histories
         write_filter_mode(phase_mode[p]);
         if (p == 3) begin
            feed_steady  = 1'b1;
            hold_request = 1'b1;
            queue_random_samples(phase_items[p]);
            wait_until_drained();
            feed_steady  = 1'b0;
            hold_request = 1'b0;
         end else begin
            queue_random_samples(phase_items[p] / 2);
            if (p == 2) wait_until_drained();
            queue_random_samples(phase_items[p] - phase_items[p] / 2);
         end
      end

      wait_until_drained();
      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("[selectable_fir_iir_filter_unit] OK");
      end else begin
         $display("[selectable_fir_iir_filter_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #(4_000_000);
      $display("[selectable_fir_iir_filter_unit] ERROR");
      $finish;
   end

endmodule
